>>> rtl/vcd_pkg.sv
package vcd_pkg;

    localparam int MAX_OBJECTS = 4096;
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = (MAX_OBJECTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W        = $clog2(NUM_WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int OBJ_W       = WA_W + BIT_W;
    localparam int CNT_W       = 13;
    localparam int IDX_W       = 16;
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_WORD   = 2'd0,
        OP_MOVE   = 2'd1,
        OP_RESIZE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        logic [WA_W-1:0]      widx;
        logic [WORD_BITS-1:0] bits;
    } t_chg;

    typedef struct packed {
        logic valid;
        t_chg chg;
    } t_qpush;

endpackage

>>> rtl/vcd_if.sv
interface vcd_in_if import vcd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       op;
    logic [WA_W-1:0]  word_index;
    logic [31:0]      vis_word;
    logic [IDX_W-1:0] old_index;
    logic [IDX_W-1:0] new_index;
    logic [CNT_W-1:0] new_count;

    modport source (
        output valid, op, word_index, vis_word, old_index, new_index, new_count,
        input  ready
    );
    modport sink (
        input  valid, op, word_index, vis_word, old_index, new_index, new_count,
        output ready
    );
endinterface

interface vcd_out_if import vcd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OBJ_W-1:0] changed_index;
    logic             last;

    modport source (output valid, changed_index, last, input ready);
    modport sink (input valid, changed_index, last, output ready);
endinterface

>>> rtl/vcd_ram.sv
module vcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/vcd_front.sv
module vcd_front import vcd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    vcd_in_if.sink  i_in,
    output t_qpush  o_push,
    input  logic    i_q_ready
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WRD  = 6'b000010,
        S_MRD  = 6'b000100,
        S_MNW  = 6'b001000,
        S_RRD  = 6'b010000,
        S_RWR  = 6'b100000
    } t_fstate;

    function automatic logic [WORD_BITS-1:0] word_mask(
        input logic [WA_W-1:0]  w,
        input logic [CNT_W-1:0] c
    );
        logic [CNT_W-BIT_W-1:0] hi;
        logic [WORD_BITS-1:0]   m;
        hi = c[CNT_W-1:BIT_W];
        if (hi > (CNT_W-BIT_W)'(w)) begin
            m = '1;
        end else if (hi == (CNT_W-BIT_W)'(w)) begin
            m = ~({WORD_BITS{1'b1}} << c[BIT_W-1:0]);
        end else begin
            m = '0;
        end
        return m;
    endfunction

    t_fstate              r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [WA_W-1:0]      r_widx;
    logic [WORD_BITS-1:0] r_word;
    logic [OBJ_W-1:0]     r_old;
    logic [OBJ_W-1:0]     r_new;
    logic                 r_bit;
    logic [CNT_W-1:0]     r_nc;
    logic [WA_W-1:0]      r_w;
    logic [WA_W-1:0]      r_hiw;
    logic [NUM_WORDS-1:0] r_vld;
    logic                 r_rvld;

    logic                 accept;
    logic                 old_in;
    logic                 new_in;
    logic [CNT_W-1:0]     nc_sat;
    logic [CNT_W-1:0]     rs_lo;
    logic [CNT_W-1:0]     rs_hi;
    logic [CNT_W-1:0]     rs_him1;
    logic                 ram_re;
    logic [WA_W-1:0]      ram_raddr;
    logic                 ram_we;
    logic [WA_W-1:0]      ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] eff;
    logic [WORD_BITS-1:0] wmask;
    logic [WORD_BITS-1:0] wnew;
    logic [WORD_BITS-1:0] wchg;
    logic [WORD_BITS-1:0] mnew;
    logic [WORD_BITS-1:0] rm_new;
    logic [WORD_BITS-1:0] rm_old;
    logic [WORD_BITS-1:0] rnew;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign old_in     = i_in.old_index < IDX_W'(r_cnt);
    assign new_in     = i_in.new_index < IDX_W'(r_cnt);
    assign nc_sat     = (i_in.new_count > CNT_W'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS)
                                                               : i_in.new_count;
    assign rs_lo      = (nc_sat < r_cnt) ? nc_sat : r_cnt;
    assign rs_hi      = (nc_sat < r_cnt) ? r_cnt : nc_sat;
    assign rs_him1    = rs_hi - CNT_W'(1);

    assign eff    = ram_rdata & {WORD_BITS{r_rvld}};
    assign wmask  = word_mask(r_widx, r_cnt);
    assign wnew   = r_word & wmask;
    assign wchg   = wnew ^ (eff & wmask);
    assign mnew   = (eff & ~(WORD_BITS'(1) << r_new[BIT_W-1:0]))
                  | (WORD_BITS'(r_bit) << r_new[BIT_W-1:0]);
    assign rm_new = word_mask(r_w, r_nc);
    assign rm_old = word_mask(r_w, r_cnt);
    assign rnew   = (eff & rm_new) | (rm_new & ~rm_old);

    always_comb begin
        n_state         = r_state;
        ram_re          = 1'b0;
        ram_raddr       = i_in.word_index;
        ram_we          = 1'b0;
        ram_waddr       = r_widx;
        ram_wdata       = wnew;
        o_push.valid    = 1'b0;
        o_push.chg.widx = r_widx;
        o_push.chg.bits = wchg;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_in.op))
                        OP_WORD: begin
                            ram_re  = 1'b1;
                            n_state = S_WRD;
                        end
                        OP_MOVE: begin
                            if (new_in) begin
                                ram_re = 1'b1;
                                if (old_in) begin
                                    ram_raddr = i_in.old_index[OBJ_W-1:BIT_W];
                                    n_state   = S_MRD;
                                end else begin
                                    ram_raddr = i_in.new_index[OBJ_W-1:BIT_W];
                                    n_state   = S_MNW;
                                end
                            end
                        end
                        OP_RESIZE: begin
                            if (rs_lo != rs_hi) begin
                                n_state = S_RRD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WRD: begin
                if (wchg == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_IDLE;
                end else if (i_q_ready) begin
                    o_push.valid = 1'b1;
                    ram_we       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_MRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_new[OBJ_W-1:BIT_W];
                n_state   = S_MNW;
            end
            S_MNW: begin
                ram_we    = 1'b1;
                ram_waddr = r_new[OBJ_W-1:BIT_W];
                ram_wdata = mnew;
                n_state   = S_IDLE;
            end
            S_RRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_w;
                n_state   = S_RWR;
            end
            S_RWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_w;
                ram_wdata = rnew;
                n_state   = (r_w == r_hiw) ? S_IDLE : S_RRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (r_state == S_RWR && r_w == r_hiw) begin
                r_cnt <= r_nc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rvld <= r_vld[ram_raddr];
        end
        if (accept) begin
            r_widx <= i_in.word_index;
            r_word <= i_in.vis_word;
            r_old  <= i_in.old_index[OBJ_W-1:0];
            r_new  <= i_in.new_index[OBJ_W-1:0];
            r_bit  <= 1'b1;
            r_nc   <= nc_sat;
            r_w    <= rs_lo[OBJ_W-1:BIT_W];
            r_hiw  <= rs_him1[OBJ_W-1:BIT_W];
        end
        if (r_state == S_MRD) begin
            r_bit <= eff[r_old[BIT_W-1:0]];
        end
        if (r_state == S_RWR) begin
            r_w <= r_w + WA_W'(1);
        end
    end

    vcd_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

>>> rtl/vcd_queue.sv
module vcd_queue import vcd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qpush i_push,
    output logic   o_ready,
    output t_chg   o_head,
    output logic   o_valid,
    input  logic   i_pop
);

    t_chg            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_ready = r_cnt != (Q_AW+1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push.valid && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.chg;
        end
    end

endmodule

>>> rtl/vcd_emit.sv
module vcd_emit import vcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chg       i_head,
    input  logic       i_hvalid,
    output logic       o_pop,
    vcd_out_if.source  o_out
);

    logic                 r_busy;
    logic [WORD_BITS-1:0] r_rem;
    logic [WA_W-1:0]      r_base;
    logic                 r_ovalid;
    logic [OBJ_W-1:0]     r_idx;
    logic                 r_last;

    logic                 adv;
    logic                 only_one;
    logic [WORD_BITS-1:0] rem_next;
    logic [BIT_W-1:0]     pos;

    assign rem_next = r_rem & (r_rem - WORD_BITS'(1));
    assign only_one = rem_next == '0;
    assign adv      = !r_ovalid || o_out.ready;
    assign o_pop    = i_hvalid && (!r_busy || (adv && only_one));

    always_comb begin
        logic [WORD_BITS-1:0] lowest;
        lowest = r_rem & (~r_rem + WORD_BITS'(1));
        pos    = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest[i]) begin
                pos = pos | BIT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (adv && r_busy) begin
                r_busy <= !only_one;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_busy) begin
            r_idx  <= {r_base, pos};
            r_last <= only_one;
        end
        if (o_pop) begin
            r_rem  <= i_head.bits;
            r_base <= i_head.widx;
        end else if (adv && r_busy) begin
            r_rem  <= rem_next;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.changed_index = r_idx;
    assign o_out.last          = r_last;

endmodule

>>> rtl/visibility_change_detector.sv
// Channel   Dir  Payload                                             Transfer
// i_in      in   op, word_index, vis_word, old_index, new_index,     valid & ready
//                new_count
// o_out     out  changed_index, last                                 valid & ready
//
// Word item: bitmap read, then write and queue push; a changed word waits for queue room.
// Move item: one bitmap read per looked-up word, then the write.
// Resize item: a read (S_RRD) and a write (S_RWR) per bitmap word between old and new count.
// Results leave the output register one per cycle while o_out is ready; a 2-entry
// queue of changed words lets the bitmap side run on while results wait, and it stalls only when full.
// Reset clears the count, the bitmap valid bits and all handshake state at once.
module visibility_change_detector import vcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vcd_in_if.sink     i_in,
    vcd_out_if.source  o_out
);

    t_qpush q_push;
    logic   q_ready;
    t_chg   q_head;
    logic   q_valid;
    logic   q_pop;

    vcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_push    (q_push),
        .i_q_ready (q_ready)
    );

    vcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_ready (q_ready),
        .o_head  (q_head),
        .o_valid (q_valid),
        .i_pop   (q_pop)
    );

    vcd_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_hvalid (q_valid),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push.valid |-> q_ready)
        else $error("push into full queue");

    a_push_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push.valid |-> (q_push.chg.bits != '0))
        else $error("queued word has no changed bit");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");

endmodule
